### rtl/core/address_list_sorter_assert.svh
// Assertion macros used by the address list sorter checker.
// Expect signals clk and rst_n in the scope of use.
`ifndef ADDRESS_LIST_SORTER_ASSERT_SVH
`define ADDRESS_LIST_SORTER_ASSERT_SVH

// Clocked property, suspended while reset is asserted.
`define ALS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that is checked during reset as well.
`define ALS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/als_pkg.sv
// Package for the address list sorter: sizes, key type and controller states.
// No dependencies.
`timescale 1ns / 1ps

package als_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int ADDR_W      = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int HALF_W      = 16;
  localparam int KEY_W       = 2 * HALF_W;

  typedef logic [KEY_W-1:0]  key_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_SCAN = 6'b000010,
    ST_PUT  = 6'b000100,
    ST_RD   = 6'b001000,
    ST_WAIT = 6'b010000,
    ST_OUT  = 6'b100000
  } state_t;

endpackage

### rtl/core/als_key_ram.sv
// Simple dual-port key memory: one write and one registered read per cycle.
// Generic; no package dependencies.
`timescale 1ns / 1ps

module als_key_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/address_list_sorter.sv
// Address list sorter top level: load, insertion into the key memory, emit.
// Depends on als_pkg and als_key_ram.
`timescale 1ns / 1ps

// Entries are kept sorted in one key memory as they arrive: each accepted
// entry is inserted by walking down from the end of the list, one memory
// read and one write per cycle, moving every stored key larger than the new
// one up by a slot. No other entry is accepted while one is being inserted.
// Ties keep arrival order. The entry with tlast closes the list; the keys are
// then read back in order: each key is read, registered and presented, and
// the next is read only once the result has been taken. No new entry is
// accepted until the final result (tlast) has been taken. Entries beyond 64
// are dropped and every result of that list carries tuser = 1. No
// initialization pass is needed after reset.

module address_list_sorter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] entry_net, [31:16] entry_node
  input  logic        in_tlast,   // last_entry
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [15:0] sorted_net, [31:16] sorted_node
  output logic        out_tlast,  // last_sorted
  output logic        out_tuser   // overflow
);

  localparam int HW = als_pkg::HALF_W;

  als_pkg::state_t state_r, state_nxt;
  als_pkg::cnt_t   count_r, count_nxt;
  logic            ovf_r, ovf_nxt;
  logic            last_r, last_nxt;
  als_pkg::addr_t  pos_r, pos_nxt;
  als_pkg::addr_t  idx_r, idx_nxt;
  als_pkg::key_t   key_r, key_nxt;
  logic            out_valid_r, out_valid_nxt;
  als_pkg::key_t   out_key_r, out_key_nxt;
  logic            out_last_r, out_last_nxt;
  logic            out_ovf_r, out_ovf_nxt;

  logic            ram_we;
  als_pkg::addr_t  ram_waddr;
  als_pkg::key_t   ram_wdata;
  als_pkg::addr_t  ram_raddr;
  als_pkg::key_t   ram_rdata;

  als_pkg::key_t   in_key;
  logic            in_acc;

  als_key_ram #(
    .DEPTH(als_pkg::MAX_ENTRIES),
    .WIDTH(als_pkg::KEY_W)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign in_tready = (state_r == als_pkg::ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign in_key    = {in_tdata[HW-1:0], in_tdata[2*HW-1:HW]};

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    last_nxt      = last_r;
    pos_nxt       = pos_r;
    idx_nxt       = idx_r;
    key_nxt       = key_r;
    out_valid_nxt = out_valid_r;
    out_key_nxt   = out_key_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;
    ram_we        = 1'b0;
    ram_waddr     = pos_r;
    ram_wdata     = key_r;
    ram_raddr     = idx_r;

    case (state_r)
      als_pkg::ST_IDLE: begin
        if (in_acc) begin
          idx_nxt  = '0;
          last_nxt = in_tlast;
          if (count_r < als_pkg::CNT_W'(als_pkg::MAX_ENTRIES)) begin
            if (count_r == '0) begin
              ram_we    = 1'b1;
              ram_waddr = '0;
              ram_wdata = in_key;
              count_nxt = als_pkg::CNT_W'(1);
              state_nxt = in_tlast ? als_pkg::ST_RD : als_pkg::ST_IDLE;
            end else begin
              key_nxt   = in_key;
              pos_nxt   = count_r[als_pkg::ADDR_W-1:0];
              ram_raddr = count_r[als_pkg::ADDR_W-1:0] - als_pkg::ADDR_W'(1);
              state_nxt = als_pkg::ST_SCAN;
            end
          end else begin
            ovf_nxt   = 1'b1;
            state_nxt = in_tlast ? als_pkg::ST_RD : als_pkg::ST_IDLE;
          end
        end
      end
      als_pkg::ST_SCAN: begin
        ram_we = 1'b1;
        if (ram_rdata > key_r) begin
          ram_wdata = ram_rdata;
          pos_nxt   = pos_r - als_pkg::ADDR_W'(1);
          if (pos_r == als_pkg::ADDR_W'(1)) begin
            state_nxt = als_pkg::ST_PUT;
          end else begin
            ram_raddr = pos_r - als_pkg::ADDR_W'(2);
          end
        end else begin
          count_nxt = count_r + als_pkg::CNT_W'(1);
          state_nxt = last_r ? als_pkg::ST_RD : als_pkg::ST_IDLE;
        end
      end
      als_pkg::ST_PUT: begin
        ram_we    = 1'b1;
        count_nxt = count_r + als_pkg::CNT_W'(1);
        state_nxt = last_r ? als_pkg::ST_RD : als_pkg::ST_IDLE;
      end
      als_pkg::ST_RD: begin
        ram_raddr = idx_r;
        state_nxt = als_pkg::ST_WAIT;
      end
      als_pkg::ST_WAIT: begin
        out_key_nxt   = ram_rdata;
        out_last_nxt  = (als_pkg::CNT_W'(idx_r) + als_pkg::CNT_W'(1)) == count_r;
        out_ovf_nxt   = ovf_r;
        out_valid_nxt = 1'b1;
        state_nxt     = als_pkg::ST_OUT;
      end
      als_pkg::ST_OUT: begin
        if (out_tready) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            count_nxt = '0;
            ovf_nxt   = 1'b0;
            state_nxt = als_pkg::ST_IDLE;
          end else begin
            idx_nxt   = idx_r + als_pkg::ADDR_W'(1);
            state_nxt = als_pkg::ST_RD;
          end
        end
      end
      default: begin
        state_nxt = als_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= als_pkg::ST_IDLE;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_r     <= last_nxt;
    pos_r      <= pos_nxt;
    idx_r      <= idx_nxt;
    key_r      <= key_nxt;
    out_key_r  <= out_key_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_key_r[HW-1:0], out_key_r[2*HW-1:HW]};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_ovf_r;

endmodule

### rtl/core/als_checker.sv
// Port-level checker for the address list sorter, bound to the top level.
// Depends on address_list_sorter_assert.svh.
`timescale 1ns / 1ps
`include "address_list_sorter_assert.svh"

module als_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tlast,
  input logic        out_tuser
);

  `ALS_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser), "stalled result changed")
  `ALS_ASSERT(a_no_overlap, !(in_tready && out_tvalid), "input taken while a result is pending")
  `ALS_ASSERT(a_close_busy, in_tvalid && in_tready && in_tlast |=> !in_tready, "input still open after closing entry")
  `ALS_ASSERT(a_run_end, out_tvalid && out_tready && out_tlast |=> in_tready && !out_tvalid, "block not idle after final result")
  `ALS_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_tvalid && in_tready, "block not idle after reset")

endmodule

bind address_list_sorter als_checker u_als_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .in_tlast  (in_tlast),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tlast (out_tlast),
  .out_tuser (out_tuser)
);
